// File: rtl/decimating_trend_recorder_assert.svh
// Assertion macros shared by the trend recorder modules.
`ifndef DECIMATING_TREND_RECORDER_ASSERT_SVH
`define DECIMATING_TREND_RECORDER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define DTR_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define DTR_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/dtr_pkg.sv
// Package: types and constants for the decimating trend recorder.
`default_nettype none
package dtr_pkg;
    localparam int WINDOW_LEN    = 256;
    localparam int HISTORY_DEPTH = 4096;
    localparam int WIN_AW  = $clog2(WINDOW_LEN);
    localparam int HIST_AW = $clog2(HISTORY_DEPTH);
    localparam int CFG_W   = 33;

    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_RD_RT  = 2'd1;
    localparam logic [1:0] REQ_RD_TR  = 2'd2;

    localparam logic [1:0] CFG_DECIM    = 2'd0;
    localparam logic [1:0] CFG_PEN      = 2'd1;
    localparam logic [1:0] CFG_LOOKBACK = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [47:0]        sample_time;
        logic signed [31:0] sample_value;
        logic [7:0]         read_index;
    } in_item_t;

    typedef struct packed {
        logic               history_stored;
        logic               pen_updated;
        logic               pen_found;
        logic signed [31:0] pen_value;
        logic signed [31:0] read_value;
    } out_item_t;
endpackage
`default_nettype wire

// File: rtl/dtr_muldiv.sv
// Iterative shift-add multiply and restoring divide for floor(mag * a / d), one bit per cycle.
`default_nettype none
`include "decimating_trend_recorder_assert.svh"
module dtr_muldiv
    import dtr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        go,
    input  wire logic [33:0] mag,
    input  wire logic [47:0] a,
    input  wire logic [47:0] d,
    output logic             done,
    output logic [33:0]      quot,
    output logic             rem_nz
);
    // Numerator is mag*a (< 2^82); divide bit-serially with the long product built in.
    logic [81:0] num_reg;
    logic [48:0] rem_reg;
    logic [47:0] a_reg, d_reg;
    logic [33:0] mag_reg;
    logic [33:0] q_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        mul_reg;
    logic [5:0]  mcnt_reg;
    logic [48:0] trial;
    logic [48:0] sh;

    assign sh    = {rem_reg[47:0], num_reg[81]};
    assign trial = sh - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mul_reg  <= 1'b0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                mul_reg  <= 1'b1;
                mcnt_reg <= 6'd0;
                num_reg  <= '0;
                mag_reg  <= mag;
                a_reg    <= a;
                d_reg    <= d;
                rem_reg  <= '0;
                q_reg    <= '0;
                cnt_reg  <= 7'd0;
            end
            else if (busy_reg && mul_reg)
            begin
                // shift-add product, one multiplier bit a cycle
                num_reg <= (num_reg << 1)
                         + (mag_reg[33] ? {34'd0, a_reg} : 82'd0);
                mag_reg <= mag_reg << 1;
                mcnt_reg <= mcnt_reg + 6'd1;
                if (mcnt_reg == 6'd33)
                    mul_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                num_reg <= num_reg << 1;
                if (!trial[48])
                begin
                    rem_reg <= trial;
                    q_reg   <= {q_reg[32:0], 1'b1};
                end
                else
                begin
                    rem_reg <= sh;
                    q_reg   <= {q_reg[32:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd81)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    assign quot   = q_reg;
    assign rem_nz = (rem_reg != '0);

    `DTR_ASSERT_NXT(a_done_pulse, clk, rst_n, done, !done)
    `DTR_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy_reg)
    `DTR_ASSERT_IMP(a_mul_busy, clk, rst_n, mul_reg && !go, busy_reg)
endmodule
`default_nettype wire

// File: rtl/decimating_trend_recorder.sv
// Top level of the decimating trend recorder: windows, history FIFO and pen sequencer.
// An unknown request goes straight to S_OUT; a window read passes S_READ and S_READW,
// a sample S_SHIFT and S_HIST, plus S_PEN for a direct pen point; S_OUT then raises done.
// A pen lookup scans the history newest first (up to 4096 entries), S_SCAN and S_SCANW for
// each entry, then interpolates with an iterative multiply and divide in dtr_muldiv.
// Throughput: one item at a time; busy is high until the strobe, which the receiver cannot stall.
// Reset: asynchronous, active low; starts a pass zeroing both windows.
`default_nettype none
`include "decimating_trend_recorder_assert.svh"
module decimating_trend_recorder
    import dtr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire in_item_t         req,
    output logic                  done,
    output out_item_t             rsp,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);
    localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_READ = 4'd2,
        S_SHIFT = 4'd3, S_HIST = 4'd4, S_SCAN = 4'd5, S_SCANW = 4'd6,
        S_NEXT = 4'd7, S_NEXTW = 4'd8, S_DIV = 4'd9, S_PEN = 4'd10,
        S_OUT = 4'd11, S_READW = 4'd12;

    logic [3:0] state_reg;
    logic [9:0] decim_reg;
    logic [31:0] pen_period_reg;
    logic signed [32:0] lookback_reg;

    // Windows are circular memories: a shift becomes a pointer advance.
    logic [31:0] rt_mem [WINDOW_LEN];
    logic [31:0] tr_mem [WINDOW_LEN];
    logic [WIN_AW-1:0] rt_ptr_reg, tr_ptr_reg;  // oldest entry
    logic [47:0] ht_mem [HISTORY_DEPTH];
    logic [31:0] hv_mem [HISTORY_DEPTH];
    logic [HIST_AW-1:0] head_reg;
    logic [HIST_AW:0]   count_reg;
    logic [9:0]  dcnt_reg;
    logic [47:0] last_pen_reg;

    in_item_t item_reg;
    out_item_t res_reg;
    logic [WIN_AW-1:0] clr_reg;
    logic [HIST_AW:0]  k_reg;
    logic [47:0] t0_reg;
    logic signed [31:0] v0_reg;
    logic [47:0] rd_t;
    logic [31:0] rd_v;
    logic [31:0] win_rd;
    logic [HIST_AW-1:0] raddr;
    logic signed [49:0] st_reg;
    logic signed [32:0] diff_reg;
    logic signed [32:0] diff_now;
    logic div_go;
    logic div_done;
    logic [33:0] div_q;
    logic div_rnz;
    logic [47:0] div_a, div_d;

    logic [HIST_AW:0] pos_sum;
    logic [HIST_AW-1:0] wr_pos;
    logic [HIST_AW:0] wsum;
    logic c_store;
    logic c_pen;
    logic [48:0] tdiff;
    logic [33:0] mag;
    logic signed [34:0] base;
    logic signed [34:0] fixed_v;

    assign busy = (state_reg != S_IDLE);

    function automatic logic [HIST_AW-1:0] wrap(input logic [HIST_AW:0] p);
        logic [HIST_AW:0] q;
        q = p - (HIST_AW+1)'(HISTORY_DEPTH);
        return (p >= (HIST_AW+1)'(HISTORY_DEPTH)) ? q[HIST_AW-1:0] : p[HIST_AW-1:0];
    endfunction

    assign pos_sum = {1'b0, head_reg} + k_reg;
    assign raddr = wrap(pos_sum);
    assign c_store = ({1'b0, dcnt_reg} + 11'd1) >= {1'b0, decim_reg};
    assign tdiff = {1'b0, item_reg.sample_time} - {1'b0, last_pen_reg};
    assign c_pen = (pen_period_reg != 32'd0) && !tdiff[48]
                && (tdiff[47:0] >= {16'd0, pen_period_reg});
    // When full, head plus count wraps onto the oldest slot, which is overwritten.
    assign wsum = {1'b0, head_reg} + count_reg;
    assign wr_pos = wrap(wsum);
    assign diff_now = 33'($signed(rd_v)) - 33'(v0_reg);
    assign mag = diff_now[32] ? 34'(-{diff_now[32], diff_now}) : 34'({1'b0, diff_now});
    assign div_a = 48'(st_reg) - t0_reg;
    assign div_d = rd_t - t0_reg;
    assign base = diff_reg[32] ? (35'(v0_reg) - $signed({1'b0, div_q}))
                               : (35'(v0_reg) + $signed({1'b0, div_q}));
    always_comb
    begin
        fixed_v = base;
        if (div_rnz && !diff_reg[32] && diff_reg != '0 && base < 0)
            fixed_v = base + 35'sd1;
        else if (div_rnz && diff_reg[32] && base > 0)
            fixed_v = base - 35'sd1;
    end

    // History memories: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_HIST && c_store)
        begin
            ht_mem[wr_pos] <= item_reg.sample_time;
            hv_mem[wr_pos] <= item_reg.sample_value;
        end
        rd_t <= ht_mem[raddr];
        rd_v <= hv_mem[raddr];
    end

    // Window memories.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            rt_mem[clr_reg] <= '0;
            tr_mem[clr_reg] <= '0;
        end
        else if (state_reg == S_SHIFT)
            rt_mem[rt_ptr_reg] <= item_reg.sample_value;
        else if (state_reg == S_PEN)
            tr_mem[tr_ptr_reg] <= res_reg.pen_value;
        if (item_reg.req_type == REQ_RD_RT)
            win_rd <= rt_mem[rt_ptr_reg + item_reg.read_index];
        else
            win_rd <= tr_mem[tr_ptr_reg + item_reg.read_index];
    end

    dtr_muldiv u_div (
        .clk(clk), .rst_n(rst_n), .go(div_go), .mag(mag), .a(div_a), .d(div_d),
        .done(div_done), .quot(div_q), .rem_nz(div_rnz)
    );
    assign div_go = (state_reg == S_NEXTW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            decim_reg <= 10'd1;
            pen_period_reg <= '0;
            lookback_reg <= '0;
            rt_ptr_reg <= '0;
            tr_ptr_reg <= '0;
            head_reg <= '0;
            count_reg <= '0;
            dcnt_reg <= '0;
            last_pen_reg <= '0;
            done <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DECIM:    decim_reg <= cfg_data[9:0];
                    CFG_PEN:      pen_period_reg <= cfg_data[31:0];
                    CFG_LOOKBACK: lookback_reg <= $signed(cfg_data);
                    default: ;
                endcase
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == WIN_AW'(WINDOW_LEN-1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        item_reg <= req;
                        res_reg <= '0;
                        if (req.req_type == REQ_SAMPLE)
                            state_reg <= S_SHIFT;
                        else if (req.req_type == REQ_RD_RT || req.req_type == REQ_RD_TR)
                            state_reg <= S_READ;
                        else
                            state_reg <= S_OUT;
                    end
                end
                S_READ:
                begin
                    // window read address settles from the held item this cycle
                    state_reg <= S_READW;
                end
                S_READW:
                begin
                    res_reg.read_value <= win_rd;
                    state_reg <= S_OUT;
                end
                S_SHIFT:
                begin
                    rt_ptr_reg <= rt_ptr_reg + 1'b1;
                    state_reg <= S_HIST;
                end
                S_HIST:
                begin
                    // push into history, then decide on a pen point
                    if (c_store)
                    begin
                        dcnt_reg <= '0;
                        res_reg.history_stored <= 1'b1;
                        if (count_reg >= (HIST_AW+1)'(HISTORY_DEPTH))
                        begin
                            head_reg <= wrap({1'b0, head_reg} + 1'b1);
                        end
                        else
                            count_reg <= count_reg + 1'b1;
                    end
                    else
                        dcnt_reg <= dcnt_reg + 10'd1;
                    st_reg <= $signed({2'b0, item_reg.sample_time}) + 50'(lookback_reg);
                    if (!c_pen)
                        state_reg <= S_OUT;
                    else
                    begin
                        last_pen_reg <= item_reg.sample_time;
                        res_reg.pen_updated <= 1'b1;
                        if (lookback_reg == '0)
                        begin
                            res_reg.pen_value <= item_reg.sample_value;
                            res_reg.pen_found <= 1'b1;
                            state_reg <= S_PEN;
                        end
                        else
                        begin
                            k_reg <= (c_store && count_reg < (HIST_AW+1)'(HISTORY_DEPTH)) ?
                                     count_reg : count_reg - 1'b1;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    // k_reg holds the entry being fetched; all-ones means none left
                    if (k_reg[HIST_AW] && count_reg != 0 && k_reg > count_reg)
                        state_reg <= S_PEN;
                    else if (count_reg == 0)
                        state_reg <= S_PEN;
                    else
                        state_reg <= S_SCANW;
                end
                S_SCANW:
                begin
                    if ($signed({2'b0, rd_t}) <= st_reg)
                    begin
                        res_reg.pen_found <= 1'b1;
                        res_reg.pen_value <= rd_v;
                        t0_reg <= rd_t;
                        v0_reg <= rd_v;
                        if (k_reg == count_reg - 1'b1)
                            state_reg <= S_PEN;
                        else
                        begin
                            k_reg <= k_reg + 1'b1;
                            state_reg <= S_NEXT;
                        end
                    end
                    else if (k_reg == '0)
                        state_reg <= S_PEN;
                    else
                    begin
                        k_reg <= k_reg - 1'b1;
                        state_reg <= S_SCAN;
                    end
                end
                S_NEXT:
                begin
                    state_reg <= S_NEXTW;
                end
                S_NEXTW:
                begin
                    diff_reg <= diff_now;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        res_reg.pen_value <= fixed_v[31:0];
                        state_reg <= S_PEN;
                    end
                end
                S_PEN:
                begin
                    tr_ptr_reg <= tr_ptr_reg + 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    done <= 1'b1;
                    rsp <= res_reg;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `DTR_ASSERT_NXT(a_done_one, clk, rst_n, done, !done)
    `DTR_ASSERT_IMP(a_no_accept_busy, clk, rst_n, done, state_reg == S_IDLE)
    `DTR_ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1, count_reg <= (HIST_AW+1)'(HISTORY_DEPTH))
endmodule
`default_nettype wire

// File: dv/tb_decimating_trend_recorder.sv
// Testbench for the decimating trend recorder: directed and random items against a predictor.
`timescale 1ns / 1ps
module tb_decimating_trend_recorder;
    import dtr_pkg::*;

    // Clock and block ports
    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    in_item_t         req;
    logic             done;
    out_item_t        rsp;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    decimating_trend_recorder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Unused request code: the block ignores it and answers with zeros.
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    // Ring of expected results; only one item is ever in flight.
    localparam int EXP_SLOTS = 16;

    // Predictor copy of the configuration and the state
    logic [9:0]         decim_factor;
    logic [31:0]        pen_period;
    logic signed [63:0] lookback;
    logic [31:0]        rt_win [WINDOW_LEN];
    logic [31:0]        tr_win [WINDOW_LEN];
    logic [47:0]        hist_stamp [HISTORY_DEPTH];
    logic [31:0]        hist_val [HISTORY_DEPTH];
    int unsigned        hist_head;
    int unsigned        hist_count;
    int unsigned        decim_cnt;
    logic [47:0]        last_pen_stamp;

    out_item_t   exp_list [EXP_SLOTS];
    int          exp_wr;
    int          exp_rd;
    int          err_cnt;
    int          burst_left;
    logic [47:0] stamp_now;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Locate entry k of the history, counted from the oldest.
    function automatic int unsigned hist_slot(input int unsigned k);
        return (hist_head + k) % HISTORY_DEPTH;
    endfunction

    // Pen value from the history at the lookup stamp, interpolated and truncated toward zero.
    function automatic logic [31:0] history_lookup(input logic signed [63:0] at,
                                                   output logic found);
        int                  j;
        logic signed [127:0] v0, v1, t0, t1, num;
        j = -1;
        for (int k = int'(hist_count) - 1; k >= 0; k--)
        begin
            if ($signed({16'd0, hist_stamp[hist_slot(k)]}) <= at)
            begin
                j = k;
                break;
            end
        end
        found = (j >= 0);
        if (j < 0)
            return '0;
        v0 = $signed(hist_val[hist_slot(j)]);
        if (j == int'(hist_count) - 1)
            return v0[31:0];
        v1 = $signed(hist_val[hist_slot(j + 1)]);
        t0 = hist_stamp[hist_slot(j)];
        t1 = hist_stamp[hist_slot(j + 1)];
        // exact weighted mean; SV division truncates toward zero
        num = v0 * (t1 - at) + v1 * (at - t0);
        num = num / (t1 - t0);
        return num[31:0];
    endfunction

    // Work out the result of one accepted item and advance the predictor state.
    function automatic out_item_t recorder_predict(input in_item_t it);
        out_item_t   o;
        int unsigned c;
        logic        f;
        o = '0;
        case (it.req_type)
            REQ_SAMPLE:
            begin
                for (int i = 0; i < WINDOW_LEN - 1; i++)
                    rt_win[i] = rt_win[i + 1];
                rt_win[WINDOW_LEN - 1] = it.sample_value;
                c = decim_cnt + 1;
                if (c >= decim_factor)
                begin
                    decim_cnt = 0;
                    if (hist_count >= HISTORY_DEPTH)
                    begin
                        hist_head  = hist_slot(1);
                        hist_count = HISTORY_DEPTH - 1;
                    end
                    hist_stamp[hist_slot(hist_count)] = it.sample_time;
                    hist_val[hist_slot(hist_count)]   = it.sample_value;
                    hist_count++;
                    o.history_stored = 1'b1;
                end
                else
                    decim_cnt = c & 10'h3FF;
                if (pen_period != 0 && it.sample_time >= last_pen_stamp &&
                    it.sample_time - last_pen_stamp >= {16'd0, pen_period})
                begin
                    if (lookback == 0)
                    begin
                        o.pen_value = it.sample_value;
                        o.pen_found = 1'b1;
                    end
                    else
                    begin
                        o.pen_value = history_lookup(
                            $signed({16'd0, it.sample_time}) + lookback, f);
                        o.pen_found = f;
                    end
                    for (int i = 0; i < WINDOW_LEN - 1; i++)
                        tr_win[i] = tr_win[i + 1];
                    tr_win[WINDOW_LEN - 1] = o.pen_value;
                    last_pen_stamp = it.sample_time;
                    o.pen_updated  = 1'b1;
                end
            end
            REQ_RD_RT: o.read_value = rt_win[it.read_index];
            REQ_RD_TR: o.read_value = tr_win[it.read_index];
            default:   o = '0;
        endcase
        return o;
    endfunction

    // Hold until every expected result has come, then let the block settle.
    task automatic drain();
        while (exp_wr != exp_rd)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register while the block is idle; mirror it in the predictor.
    task automatic reg_write(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        start <= 1'b0;
        drain();
        while (busy)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DECIM:    decim_factor = data[9:0];
            CFG_PEN:      pen_period   = data[31:0];
            CFG_LOOKBACK: lookback     = {{31{data[32]}}, data};
            default:      ;
        endcase
    endtask

    // Offer one item; advance to the edge that accepts it and queue its prediction.
    task automatic send_item(input in_item_t it);
        if (burst_left == 0)
        begin
            // end of burst: drop start for a random gap
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
        else
            burst_left--;
        start <= 1'b1;
        req   <= it;
        do
            @(posedge clk);
        while (busy);
        exp_list[exp_wr % EXP_SLOTS] = recorder_predict(it);
        exp_wr++;
    endtask

    task automatic send_sample(input logic [47:0] stamp, input logic [31:0] val);
        in_item_t it;
        it              = '0;
        it.req_type     = REQ_SAMPLE;
        it.sample_time  = stamp;
        it.sample_value = val;
        it.read_index   = 8'($urandom);
        send_item(it);
    endtask

    task automatic send_read(input logic [1:0] kind, input logic [7:0] idx);
        in_item_t it;
        it              = '0;
        it.req_type     = kind;
        it.sample_time  = {16'($urandom), 32'($urandom)};
        it.sample_value = $urandom;
        it.read_index   = idx;
        send_item(it);
    endtask

    // Compare each result with the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && done)
        begin
            if (exp_wr == exp_rd)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result %h", rsp);
            end
            else
            begin
                want = exp_list[exp_rd % EXP_SLOTS];
                exp_rd++;
                if (rsp.history_stored !== want.history_stored ||
                    rsp.pen_updated !== want.pen_updated ||
                    rsp.pen_found !== want.pen_found ||
                    rsp.pen_value !== want.pen_value ||
                    rsp.read_value !== want.read_value)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: want %b%b%b pv=%h rv=%h, got %b%b%b pv=%h rv=%h",
                                 want.history_stored, want.pen_updated, want.pen_found,
                                 want.pen_value, want.read_value,
                                 rsp.history_stored, rsp.pen_updated, rsp.pen_found,
                                 rsp.pen_value, rsp.read_value);
                end
            end
        end
    end

    // Windows read back as zero after reset, extremes of the index, then an unused request.
    task automatic test_reset_reads();
        send_read(REQ_RD_RT, 8'd0);
        send_read(REQ_RD_RT, 8'd255);
        send_read(REQ_RD_TR, 8'd0);
        send_read(REQ_RD_TR, 8'd255);
        send_read(REQ_UNUSED, 8'd255);
    endtask

    // Direct pen points: value extremes, then read them back from both windows.
    task automatic test_direct_pen();
        reg_write(CFG_PEN, 33'd1);
        reg_write(CFG_LOOKBACK, '0);
        send_sample(48'd10, 32'h7FFF_FFFF);
        send_sample(48'd11, 32'h8000_0000);
        send_sample(48'd11, 32'h0000_0000);   // same stamp: too soon for a pen point
        send_sample(48'd12, 32'hFFFF_FFFF);
        send_read(REQ_RD_RT, 8'd254);
        send_read(REQ_RD_TR, 8'd255);
    endtask

    // Decimation: zero factor, a large factor of 1000, and a counter left above a lowered factor.
    task automatic test_decimation();
        reg_write(CFG_DECIM, '0);
        send_sample(48'd20, 32'h0001_0000);
        send_sample(48'd21, 32'h0002_0000);
        reg_write(CFG_DECIM, 33'd1000);
        for (int i = 0; i < 4; i++)
            send_sample(48'd22 + i, $urandom);
        reg_write(CFG_DECIM, 33'd2);
        send_sample(48'd30, 32'h0003_0000);
        send_sample(48'd31, 32'h0004_0000);
    endtask

    // Lookback: interpolation both ways, nothing old enough, a large negative lookback.
    task automatic test_lookback();
        reg_write(CFG_DECIM, 33'd1);
        reg_write(CFG_LOOKBACK, -33'sd5);
        send_sample(48'd40, 32'h0010_0000);
        send_sample(48'd47, 32'hFFF0_0003);   // lookup between 40 and 47, falling
        send_sample(48'd53, 32'h0020_0001);   // rising from 47 to 53
        send_sample(48'd100, 32'h1234_5678);  // lookup between 53 and 100
        reg_write(CFG_LOOKBACK, {1'b1, 32'h0000_0001});
        send_sample(48'd101, 32'h0000_0001);  // nothing old enough
    endtask

    // Stamp extremes, widest pen period, and time going backwards.
    task automatic test_stamp_edges();
        reg_write(CFG_LOOKBACK, -33'sd3);
        reg_write(CFG_PEN, 33'hFFFF_FFFF);
        send_sample(48'h7FFF_FFFF_FFFF, 32'h5555_5555);
        send_sample(48'hFFFF_FFFF_FFFF, 32'hAAAA_AAAA);
        send_sample(48'h0000_0000_0005, 32'h0000_0007);  // earlier than last pen point
        send_read(REQ_RD_TR, 8'd255);
    endtask

    // Random segments: each with its own settings, mostly well-formed rising stamps.
    task automatic test_random();
        int kind;
        for (int seg = 0; seg < 5; seg++)
        begin
            reg_write(CFG_DECIM, (seg == 4) ? 33'd1000 : 33'($urandom_range(0, 4)));
            reg_write(CFG_PEN, (seg == 3) ? 33'd0 : 33'($urandom_range(1, 60)));
            reg_write(CFG_LOOKBACK, (seg == 1) ? 33'd0 : -33'($urandom_range(1, 400)));
            stamp_now = 48'd1000 + 48'(seg) * 48'd100000;
            for (int n = 0; n < 23; n++)
            begin
                kind = $urandom_range(0, 19);
                if (kind < 14)
                begin
                    stamp_now += $urandom_range(0, 40);
                    send_sample(stamp_now, $urandom);
                end
                else if (kind == 14)
                    send_sample(stamp_now - $urandom_range(1, 50), $urandom);
                else if (kind < 17)
                    send_read(REQ_RD_RT, 8'($urandom));
                else if (kind < 19)
                    send_read(REQ_RD_TR, 8'($urandom));
                else
                    send_read(REQ_UNUSED, 8'($urandom));
                // hold off once per segment until everything has come back
                if (n == 14)
                begin
                    start <= 1'b0;
                    drain();
                end
            end
        end
    endtask

    initial
    begin
        err_cnt        = 0;
        exp_wr         = 0;
        exp_rd         = 0;
        burst_left     = 0;
        decim_factor   = 10'd1;
        pen_period     = '0;
        lookback       = '0;
        hist_head      = 0;
        hist_count     = 0;
        decim_cnt      = 0;
        last_pen_stamp = '0;
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            rt_win[i] = '0;
            tr_win[i] = '0;
        end
        rst_n     <= 1'b0;
        start     <= 1'b0;
        req       <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_DECIM;
        cfg_data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_reads();
        test_direct_pen();
        test_decimation();
        test_lookback();
        test_random();
        test_stamp_edges();

        start <= 1'b0;
        drain();
        repeat (20) @(posedge clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Limit: far beyond the slowest correct run.
    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/dtr_pkg.sv
rtl/dtr_muldiv.sv
rtl/decimating_trend_recorder.sv
dv/tb_decimating_trend_recorder.sv
